// ----- rtl/core/sld_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sld_pkg: shared types and constants of the packet deframer
// Sync byte, register codes, parser phases and the control structs that pass
// between the front parser and the drain side.
// ============================================================================
package sld_pkg;

	localparam int          MAX_PAYLOAD_DEF = 60;
	localparam logic [7:0]  SYNC_BYTE       = 8'hEE;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;

	// register index, taken from paddr[2]
	localparam logic        REG_TIMEOUT     = 1'b0;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_CMD     = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	// verified frame handed to the queue
	typedef struct packed {
		logic push;
		logic bank;
	} desc_ctl_t;

	// drain side has read the last byte of a bank
	typedef struct packed {
		logic release_bank;
		logic bank;
	} drain_ctl_t;

endpackage

// ----- rtl/core/sld_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sld_front: frame parser
// Hunts for sync, tracks command, length, payload and checksum, keeps the
// running sum and tick timeout, writes frame bytes into one of two banks and
// posts a descriptor when the checksum matches.
// ============================================================================
module sld_front import sld_pkg::*; #(
	parameter  int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int DEPTH       = MAX_PAYLOAD + 4,
	localparam int IDX_W       = $clog2(DEPTH),
	localparam int FILL_W      = $clog2(DEPTH + 1),
	localparam int REM_W       = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       timeout_ticks,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	output desc_ctl_t         desc,
	output logic [FILL_W-1:0] desc_len,
	input  drain_ctl_t        drain,
	output logic [1:0]        busy,
	output logic              mem_we,
	output logic [IDX_W:0]    mem_waddr,
	output logic [7:0]        mem_wdata
);

	phase_t            phase_q, phase_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic [7:0]        sum_q, sum_d;
	logic [FILL_W-1:0] fill_q, fill_d, fill_base;
	logic [15:0]       elapsed_q, elapsed_d;
	logic              wr_bank_q;
	logic [1:0]        busy_q;
	logic              accept, is_byte, is_tick, store, push;

	assign s_tready = !busy_q[wr_bank_q];
	assign accept   = s_tvalid && s_tready;
	assign is_byte  = accept && !s_tuser;
	assign is_tick  = accept && s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		sum_d     = sum_q;
		elapsed_d = elapsed_q;
		fill_base = fill_q;
		store     = 1'b0;
		push      = 1'b0;
		if (is_tick && phase_q != PH_HUNT) begin
			elapsed_d = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
			if (elapsed_d > timeout_ticks) begin
				phase_d = PH_HUNT;
			end
		end else if (is_byte) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (s_tdata == SYNC_BYTE) begin
						fill_base = '0;
						store     = 1'b1;
						sum_d     = SYNC_BYTE;
						elapsed_d = '0;
						phase_d   = PH_CMD;
					end
				end
				PH_CMD: begin
					store   = 1'b1;
					sum_d   = sum_q + s_tdata;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					store = 1'b1;
					sum_d = sum_q + s_tdata;
					if (s_tdata > 8'(MAX_PAYLOAD)) begin
						phase_d = PH_HUNT;
					end else if (s_tdata == 8'd0) begin
						phase_d = PH_CHECK;
					end else begin
						rem_d   = s_tdata[REM_W-1:0];
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					store = 1'b1;
					sum_d = sum_q + s_tdata;
					rem_d = (rem_q != '0) ? rem_q - REM_W'(1) : rem_q;
					if (rem_q <= REM_W'(1)) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					store   = 1'b1;
					push    = (sum_q == s_tdata);
					phase_d = PH_HUNT;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	assign mem_we    = store && (fill_base < FILL_W'(DEPTH));
	assign fill_d    = mem_we ? fill_base + FILL_W'(1) : fill_base;
	assign mem_waddr = {wr_bank_q, fill_base[IDX_W-1:0]};
	assign mem_wdata = s_tdata;

	assign desc.push = push;
	assign desc.bank = wr_bank_q;
	assign desc_len  = fill_d;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			sum_q     <= '0;
			fill_q    <= '0;
			elapsed_q <= '0;
			wr_bank_q <= 1'b0;
			busy_q    <= '0;
		end else begin
			rem_q     <= rem_d;
			sum_q     <= sum_d;
			fill_q    <= fill_d;
			elapsed_q <= elapsed_d;
			if (push) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (drain.release_bank) begin
				busy_q[drain.bank] <= 1'b0;
			end
			if (push) begin
				busy_q[wr_bank_q] <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/sld_desc_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sld_desc_fifo: two-entry descriptor queue
// Holds bank and length of verified frames waiting for the drain side.
// ============================================================================
module sld_desc_fifo import sld_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic          not_empty,
	output logic          full,
	output logic [DW-1:0] head
);

	logic [DW-1:0] entry_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push && !full, pop && not_empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/sld_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sld_back: frame store and drain
// Two-bank byte store written by the parser; replays a verified frame one
// byte per cycle while m_tready is high, through a registered read port
// that doubles as the output register.
// ============================================================================
module sld_back import sld_pkg::*; #(
	parameter  int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int DEPTH       = MAX_PAYLOAD + 4,
	localparam int IDX_W       = $clog2(DEPTH),
	localparam int FILL_W      = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mem_we,
	input  logic [IDX_W:0]    mem_waddr,
	input  logic [7:0]        mem_wdata,
	input  logic              q_valid,
	input  logic              q_bank,
	input  logic [FILL_W-1:0] q_len,
	output logic              q_pop,
	output drain_ctl_t        drain,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	logic [7:0]        mem_q [2**(IDX_W+1)];
	logic [7:0]        rd_data_q;
	logic              last_q, out_valid_q;
	logic              active_q, bank_q;
	logic [FILL_W-1:0] len_q, idx_q;
	logic              rd_en, rd_last;

	assign q_pop   = !active_q && q_valid;
	assign rd_en   = active_q && (!out_valid_q || m_tready);
	assign rd_last = (FILL_W'(idx_q + FILL_W'(1)) == len_q);

	assign drain.release_bank = rd_en && rd_last;
	assign drain.bank         = bank_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[{bank_q, idx_q[IDX_W-1:0]}];
			last_q    <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			bank_q      <= 1'b0;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				bank_q   <= q_bank;
				len_q    <= q_len;
				idx_q    <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + FILL_W'(1);
				if (rd_last) begin
					active_q <= 1'b0;
				end
			end
			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rd_data_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/core/sync_length_sum_packet_deframer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sync_length_sum_packet_deframer: sync / length / sum-8 packet deframer
// Parses sync, command, length, payload and checksum bytes from a word
// stream with tick events, and forwards each verified frame whole.
// ============================================================================
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: data_byte; tuser: req_type
//  m_*     | out | m_tvalid/m_tready | tdata: packet_byte; tlast: last_byte
//  apb     | in  | psel/penable      | reg 0 @ 0x0: timeout_ticks[15:0]
//
//  Input: one word per cycle while s_tready is high; the parser finishes
//  each word in the cycle it is taken. Output: one frame byte per cycle
//  while m_tready is high, set by the single read port of the frame store.
//  A frame is 4 to MAX_PAYLOAD+4 bytes; after its checksum word its first
//  byte passes the queue, drain start and read port. Two banks: s_tready
//  drops only when a frame is verified while the other bank still drains.
//  Reset: asynchronous, active low; no clearing pass, store contents are
//  only read where written during the same frame.
//  Either side may stall freely; m_* holds its word while m_tready is low.
//
module sync_length_sum_packet_deframer import sld_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] req_type: 0 byte, 1 tick
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast    // last_byte
);

	localparam int DEPTH  = MAX_PAYLOAD + 4;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [15:0]       timeout_q;
	desc_ctl_t         desc;
	drain_ctl_t        drain;
	logic [FILL_W-1:0] desc_len, q_len;
	logic [1:0]        busy;
	logic              mem_we;
	logic [IDX_W:0]    mem_waddr;
	logic [7:0]        mem_wdata;
	logic              q_valid, q_full, q_pop, q_bank;

	// ---- configuration register -------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	// ---- front: parser and store writer -----------------------------------
	sld_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.desc          (desc),
		.desc_len      (desc_len),
		.drain         (drain),
		.busy          (busy),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata)
	);

	// ---- queue of verified frames (bank, length) --------------------------
	sld_desc_fifo #(.DW(FILL_W + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (desc.push),
		.push_data ({desc.bank, desc_len}),
		.pop       (q_pop),
		.not_empty (q_valid),
		.full      (q_full),
		.head      ({q_bank, q_len})
	);

	// ---- back: store and drain --------------------------------------------
	sld_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.q_valid   (q_valid),
		.q_bank    (q_bank),
		.q_len     (q_len),
		.q_pop     (q_pop),
		.drain     (drain),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// ---- assertions -------------------------------------------------------
	// a frame is only committed into a bank that is not still draining
	a_push_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		desc.push |-> !busy[desc.bank])
		else $error("frame committed into a busy bank");

	// two busy banks bound the queue, so a push never meets a full queue
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		desc.push |-> !q_full)
		else $error("descriptor queue overflow");

	// drain releases only a bank that was committed, and frees it next cycle
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drain.release_bank |-> busy[drain.bank] ##1 !busy[$past(drain.bank)])
		else $error("bank release mismatch");

endmodule

// ----- dv/sync_length_sum_packet_deframer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sync_length_sum_packet_deframer_tb: self-checking bench for the deframer
// Drives byte and tick words into the parser and predicts every verified
// frame byte, then compares the output stream against that prediction. Runs
// directed corner frames, then random frame traffic under several timeout
// settings and sender / receiver idling mixes.
// ============================================================================
module sync_length_sum_packet_deframer_tb;
	import sld_pkg::*;

	localparam int          CLK_HALF    = 2;
	localparam int          CYCLE_LIMIT = 300000;
	localparam int          DRAIN_WAIT  = 40;
	localparam int          PHASE_WORDS = 20;
	localparam logic [2:0]  TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

	// ------------------------------------------------------------------------
	// Frame predictor: tracks the parser state and holds the frame bytes that
	// must come out, oldest first.
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
		} frame_word_t;

		phase_t      parse_phase;
		logic [5:0]  payload_left;
		logic [7:0]  frame_sum;
		int          fill;
		logic [7:0]  frame_buf[64];
		logic [15:0] tick_count;
		logic [15:0] timeout_limit;
		frame_word_t verified_bytes[$];

		int mismatches;
		int bytes_checked;
		int frames_ok;
		int frames_bad_sum;
		int frames_timed_out;
		int frames_too_long;

		function new();
			parse_phase   = PH_HUNT;
			payload_left  = '0;
			frame_sum     = '0;
			fill          = 0;
			tick_count    = '0;
			timeout_limit = TIMEOUT_RESET;
		endfunction

		function void set_timeout(logic [15:0] value);
			timeout_limit = value;
		endfunction

		function int pending();
			return verified_bytes.size();
		endfunction

		function void store(logic [7:0] b);
			if (fill < 64) begin
				frame_buf[fill] = b;
				fill++;
			end
		endfunction

		// Returns 1 when the word changed parser state.
		function bit parse_word(bit is_tick, logic [7:0] b);
			if (is_tick) begin
				if (parse_phase == PH_HUNT)
					return 1'b0;
				if (tick_count != 16'hFFFF)
					tick_count++;
				if (tick_count > timeout_limit) begin
					parse_phase = PH_HUNT;
					frames_timed_out++;
				end
				return 1'b1;
			end
			case (parse_phase)
				PH_HUNT: begin
					if (b != SYNC_BYTE)
						return 1'b0;
					fill = 0;
					store(b);
					frame_sum   = SYNC_BYTE;
					tick_count  = '0;
					parse_phase = PH_CMD;
				end
				PH_CMD: begin
					store(b);
					frame_sum   += b;
					parse_phase = PH_LEN;
				end
				PH_LEN: begin
					store(b);
					frame_sum += b;
					if (b > MAX_PAYLOAD_DEF) begin
						parse_phase = PH_HUNT;
						frames_too_long++;
					end else if (b == 8'd0) begin
						parse_phase = PH_CHECK;
					end else begin
						payload_left = b[5:0];
						parse_phase  = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					store(b);
					frame_sum += b;
					if (payload_left != 0)
						payload_left--;
					if (payload_left == 0)
						parse_phase = PH_CHECK;
				end
				default: begin
					store(b);
					if (frame_sum == b) begin
						for (int i = 0; i < fill; i++)
							verified_bytes.push_back('{data: frame_buf[i], last: (i == fill - 1)});
						frames_ok++;
					end else begin
						frames_bad_sum++;
					end
					parse_phase = PH_HUNT;
				end
			endcase
			return 1'b1;
		endfunction

		function void check_word(logic [7:0] data, logic last);
			frame_word_t exp_word;
			bytes_checked++;
			if (verified_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: unexpected word data=%02h last=%0b", data, last);
				return;
			end
			exp_word = verified_bytes.pop_front();
			if (data !== exp_word.data || last !== exp_word.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
						exp_word.data, exp_word.last, data, last);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] req_type: 0 byte, 1 tick
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] packet_byte
	logic        m_tlast;   // last_byte

	frame_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	int              effective_words;

	sync_length_sum_packet_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost frame byte ends up here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[sync_length_sum_packet_deframer] ERROR");
		$finish;
	end

	// Output side: sample with pre-edge values, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// One word into the parser; valid stays up after the accept so back-to-back
	// words never lower and raise it in the same step.
	task automatic send_word(bit is_tick, logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_tick;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		if (sb.parse_word(is_tick, b))
			effective_words++;
	endtask

	// Sends sync..payload, then the checksum (corrupted on request); ticks are
	// sprinkled in front of bytes.
	task automatic send_body(logic [7:0] body[$], bit corrupt, int tick_pct);
		logic [7:0] sum;
		sum = '0;
		foreach (body[i]) begin
			sum += body[i];
			if ($urandom_range(99) < tick_pct)
				send_word(1'b1, 8'($urandom_range(255)));
			send_word(1'b0, body[i]);
		end
		if (corrupt)
			sum ^= 8'($urandom_range(1, 255));
		send_word(1'b0, sum);
	endtask

	task automatic send_frame(int len, bit corrupt, int tick_pct);
		logic [7:0] body[$];
		body = {SYNC_BYTE, 8'($urandom_range(255)), 8'(len)};
		repeat (len) body.push_back(8'($urandom_range(255)));
		send_body(body, corrupt, tick_pct);
	endtask

	// Register write: setup cycle, then access; written when pready is seen.
	task automatic write_timeout(logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TIMEOUT_ADDR;
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_timeout(value);
	endtask

	// Drop valid, let every predicted byte drain, then give the parser room.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Mostly well-formed frames, some bad sums, over-length, truncated frames
	// left to time out, and stray words.
	task automatic random_traffic(int target);
		int start_words;
		int pick;
		int sel;
		int len;
		start_words = effective_words;
		while (effective_words - start_words < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				sel = $urandom_range(11);
				len = (sel == 0) ? MAX_PAYLOAD_DEF :
					(sel == 1) ? $urandom_range(7, MAX_PAYLOAD_DEF) : $urandom_range(0, 6);
				send_frame(len, $urandom_range(99) < 20, 10);
			end else if (pick < 80) begin
				send_word(1'b0, SYNC_BYTE);
				send_word(1'b0, 8'($urandom_range(255)));
				send_word(1'b0, 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
			end else if (pick < 90) begin
				len = $urandom_range(1, 8);
				send_word(1'b0, SYNC_BYTE);
				send_word(1'b0, 8'($urandom_range(255)));
				send_word(1'b0, 8'(len));
				repeat ($urandom_range(0, len - 1)) send_word(1'b0, 8'($urandom_range(255)));
				repeat ($urandom_range(1, 6)) send_word(1'b1, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] body[$];
		logic [15:0] mid_timeout;

		sb              = new();
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		effective_words = 0;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		s_tdata  <= '0;
		m_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at the reset timeout, no idling.
		send_word(1'b1, 8'hA5);             // tick while hunting
		send_word(1'b0, 8'h00);             // non-sync bytes while hunting
		send_word(1'b0, 8'hFF);
		body = {SYNC_BYTE, 8'h00, 8'h00};   // zero length, good sum
		send_body(body, 1'b0, 0);
		body = {SYNC_BYTE, 8'hFF, 8'h00};   // zero length, bad sum
		send_body(body, 1'b1, 0);
		send_word(1'b0, SYNC_BYTE);         // just over max length
		send_word(1'b0, 8'h12);
		send_word(1'b0, 8'(MAX_PAYLOAD_DEF + 1));
		send_word(1'b0, SYNC_BYTE);         // length byte at its top value
		send_word(1'b0, 8'h34);
		send_word(1'b0, 8'hFF);
		body = {SYNC_BYTE, 8'h5A, 8'h01, SYNC_BYTE}; // sync byte as payload
		send_body(body, 1'b0, 0);

		// Phase 0: reset timeout, one max-size frame, no idling.
		send_frame(MAX_PAYLOAD_DEF, 1'b0, 0);
		random_traffic(PHASE_WORDS);
		settle();

		// Phase 1: timeout of one tick, sender idles.
		write_timeout(16'd1);
		send_idle_pct  = 51;
		recv_stall_pct = 0;
		random_traffic(PHASE_WORDS);
		settle();

		// Phase 2: timeout never fires, receiver stalls.
		write_timeout(16'hFFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		random_traffic(PHASE_WORDS);
		settle();

		// Phase 3: small random timeout, both sides idle.
		mid_timeout = 16'($urandom_range(2, 12));
		write_timeout(mid_timeout);
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		random_traffic(PHASE_WORDS);
		settle();

		$display("coverage: %0d parsing words, %0d frame bytes out; %0d frames passed,",
			effective_words, sb.bytes_checked, sb.frames_ok);
		$display("  %0d bad sums, %0d timeouts, %0d over length; timeouts 5000/1/65535/%0d",
			sb.frames_bad_sum, sb.frames_timed_out, sb.frames_too_long, mid_timeout);
		if (sb.mismatches == 0) begin
			$display("[sync_length_sum_packet_deframer] OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("[sync_length_sum_packet_deframer] ERROR");
		end
		$finish;
	end

endmodule
